// ===== src/pwcs_pkg.sv =====
// Package for the peak window contrast score block.
// Holds the sizing constants, the sequencer state type and derived widths.
// No dependencies.
package pwcs_pkg;

  // Store depth and window divisor.
  localparam int MAX_SAMPLES    = 1024;
  localparam int WINDOW_DIVISOR = 5;

  // Field widths fixed by the interface.
  localparam int AREA_W  = 32;
  localparam int SCORE_W = 32;
  localparam int FRAC_W  = 16;

  // Store address, sample count and window remainder counter widths.
  localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUB_W  = (WINDOW_DIVISOR > 1) ? $clog2(WINDOW_DIVISOR) : 1;

  // Sums over the store, and the products of a sum with a sample count.
  localparam int SUM_W  = AREA_W + CNT_W;
  localparam int PROD_W = SUM_W + CNT_W;

  // The early rule compares (2L)^2 * 256 = L^2 * 2^10 with the peak.
  localparam int EARLY_SHIFT = 10;
  localparam int LIM_W       = PROD_W + EARLY_SHIFT;

  // Quotient step counter of the divider.
  localparam int STEP_W = $clog2(SCORE_W);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SQUARE,
    ST_EARLY,
    ST_BOUNDS,
    ST_COUNTS,
    ST_SWEEP,
    ST_DRAIN,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// ===== src/peak_window_contrast_score.sv =====
// Top level of the peak window contrast score block.
// Depends on pwcs_pkg and pwcs_divider.
//
// Usage: area samples arrive on the sample channel (sample_valid, sample_stall,
// area_sample, last_item), one per transfer, with last_item set on the final
// sample of a profile. Each sample is written to an on-chip store and the peak
// and its first index are tracked. Samples beyond the store depth are dropped
// and flagged in store_overflow.
// The transfer with last_item set starts the closing pass. The block raises
// sample_stall until the pass ends. The pass squares the length for the early
// rule, sweeps the L stored samples once through the store read port to sum
// the window and the tails, runs two products through one shared multiplier,
// and then a divider that yields one quotient bit per cycle.
// Throughput: one sample per cycle while loading. The length of the closing pass
// is set by the store sweep and the 32-step divider; the early rule ends it
// before the sweep, and a saturated ratio before the divider.
// One result transfer on the result channel follows each profile. The result
// register is separate, so loading of the next profile goes on while the
// receiver stalls; a finished pass waits only if the previous result is still
// held. Reset clears the profile state and the result valid; the store needs
// no clearing because only samples of the current profile are read.
module peak_window_contrast_score import pwcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [AREA_W-1:0]  area_sample,
  input  logic               last_item,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [SCORE_W-1:0] score,
  output logic               too_short,
  output logic               saturated,
  output logic               store_overflow
);

  state_t state, state_next;

  logic [AREA_W-1:0]  area_store [MAX_SAMPLES];

  logic               sample_accept;
  logic               store_we;
  logic               out_free;

  logic [CNT_W-1:0]   sample_count;
  logic [AREA_W-1:0]  peak_value;
  logic [ADDR_W-1:0]  peak_index;
  logic               overflow_seen;
  logic [CNT_W-1:0]   half_width;
  logic [SUB_W-1:0]   width_sub;

  logic [CNT_W-1:0]   win_start, win_end, tail_lo, tail_hi, win_count, tail_count;
  logic [CNT_W-1:0]   peak_ext;
  logic [CNT_W:0]     end_sum;
  logic [CNT_W:0]     hi_sum;

  logic [CNT_W-1:0]   sweep_addr;
  logic [CNT_W-1:0]   rd_idx;
  logic               rd_valid;
  logic [AREA_W-1:0]  rd_data;
  logic [SUM_W-1:0]   win_sum, tail_sum;

  logic [SUM_W-1:0]   mul_a;
  logic [CNT_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  num;

  logic               early_short;
  logic               ratio_sat;
  logic               div_start;
  logic               div_done;
  logic [SCORE_W-1:0] div_quotient;

  logic [SCORE_W-1:0] res_score;
  logic               res_short;
  logic               res_sat;

  assign sample_accept = sample_valid && !sample_stall;
  assign store_we      = sample_accept && (sample_count < CNT_W'(MAX_SAMPLES));
  assign out_free      = !result_valid || !result_stall;

  // Early rule and saturation tests on the multiplier output.
  assign early_short = {prod, {EARLY_SHIFT{1'b0}}} < LIM_W'(peak_value);
  assign ratio_sat   = (tail_sum == '0) ||
                       ((PROD_W + FRAC_W)'(num) >= {prod, {FRAC_W{1'b0}}});

  // Window bounds from the peak index and half width.
  assign peak_ext = CNT_W'(peak_index);
  assign end_sum  = {1'b0, peak_ext} + {1'b0, half_width};
  assign hi_sum   = {1'b0, sample_count} + {1'b0, win_end};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, stall, divider start and multiplier operands.
  always_comb begin
    state_next   = state;
    sample_stall = (state != ST_LOAD);
    div_start    = 1'b0;
    mul_a        = tail_sum;
    mul_b        = win_count;
    case (state)
      ST_LOAD: begin
        if (sample_accept && last_item) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        mul_a      = SUM_W'(sample_count);
        mul_b      = sample_count;
        state_next = ST_EARLY;
      end
      ST_EARLY: begin
        state_next = early_short ? ST_FINISH : ST_BOUNDS;
      end
      ST_BOUNDS: begin
        state_next = ST_COUNTS;
      end
      ST_COUNTS: begin
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sweep_addr == sample_count - 1'b1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_MUL_NUM;
      end
      ST_MUL_NUM: begin
        mul_a      = win_sum;
        mul_b      = tail_count;
        state_next = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        mul_a      = tail_sum;
        mul_b      = win_count;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (ratio_sat) begin
          state_next = ST_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Sample store: one write per stored sample, one registered read per sweep cycle.
  always_ff @(posedge clk) begin
    if (store_we) begin
      area_store[sample_count[ADDR_W-1:0]] <= area_sample;
    end
    rd_data <= area_store[sweep_addr[ADDR_W-1:0]];
  end

  // Profile tracking: length, peak, overflow and the running length / divisor.
  always_ff @(posedge clk) begin
    if (rst || (state == ST_FINISH && out_free)) begin
      sample_count  <= '0;
      peak_value    <= '0;
      peak_index    <= '0;
      overflow_seen <= 1'b0;
      half_width    <= '0;
      width_sub     <= '0;
    end else if (store_we) begin
      sample_count <= sample_count + 1'b1;
      if (area_sample > peak_value) begin
        peak_value <= area_sample;
        peak_index <= sample_count[ADDR_W-1:0];
      end
      if (width_sub == SUB_W'(WINDOW_DIVISOR - 1)) begin
        width_sub  <= '0;
        half_width <= half_width + 1'b1;
      end else begin
        width_sub <= width_sub + 1'b1;
      end
    end else if (sample_accept) begin
      overflow_seen <= 1'b1;
    end
  end

  // Shared multiplier with a registered product.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (state == ST_MUL_DEN) begin
      num <= prod;
    end
  end

  // Window and tail bounds, worked out in the ST_EARLY, ST_BOUNDS and ST_COUNTS states.
  always_ff @(posedge clk) begin
    case (state)
      ST_EARLY: begin
        win_start <= (peak_ext >= half_width) ? peak_ext - half_width : '0;
        if (end_sum > {1'b0, sample_count - 1'b1}) begin
          win_end <= sample_count - 1'b1;
        end else begin
          win_end <= end_sum[CNT_W-1:0];
        end
      end
      ST_BOUNDS: begin
        win_count <= win_end - win_start + 1'b1;
        tail_lo   <= win_start >> 1;
        tail_hi   <= hi_sum[CNT_W:1];
      end
      ST_COUNTS: begin
        tail_count <= sample_count - tail_hi + tail_lo;
      end
      default: begin
      end
    endcase
  end

  // Store sweep: issue one address per cycle, accumulate the data in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SWEEP);
    end
    rd_idx <= sweep_addr;
    if (state == ST_COUNTS) begin
      sweep_addr <= '0;
      win_sum    <= '0;
      tail_sum   <= '0;
    end else begin
      if (state == ST_SWEEP) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (rd_valid) begin
        if (rd_idx >= win_start && rd_idx <= win_end) begin
          win_sum <= win_sum + SUM_W'(rd_data);
        end
        if (rd_idx < tail_lo || rd_idx >= tail_hi) begin
          tail_sum <= tail_sum + SUM_W'(rd_data);
        end
      end
    end
  end

  pwcs_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .den      (prod),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Pending result of the closing pass.
  always_ff @(posedge clk) begin
    if (state == ST_EARLY && early_short) begin
      res_score <= '0;
      res_short <= 1'b1;
      res_sat   <= 1'b0;
    end else if (state == ST_CHECK && ratio_sat) begin
      res_score <= '1;
      res_short <= 1'b0;
      res_sat   <= 1'b1;
    end else if (state == ST_DIVIDE && div_done) begin
      res_score <= div_quotient;
      res_short <= 1'b0;
      res_sat   <= 1'b0;
    end
  end

  // Output register: loaded when the pass finishes and the previous transfer is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (state == ST_FINISH && out_free) begin
      score          <= res_score;
      too_short      <= res_short;
      saturated      <= res_sat;
      store_overflow <= overflow_seen;
    end
  end

endmodule

// ===== src/pwcs_divider.sv =====
// Restoring divider that forms floor(num * 2^16 / den) one quotient bit per cycle.
// The caller guarantees the quotient fits in SCORE_W bits and den is nonzero.
// Depends on pwcs_pkg.
module pwcs_divider import pwcs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PROD_W-1:0]   num,
  input  logic [PROD_W-1:0]   den,
  output logic                done,
  output logic [SCORE_W-1:0]  quotient
);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [PROD_W-1:0]   rem;
  logic [PROD_W-1:0]   den_q;
  logic [SCORE_W-1:0]  low_bits;
  logic [PROD_W:0]     trial;
  logic [PROD_W:0]     diff;

  // Shift the next dividend bit into the remainder and try a subtraction.
  assign trial = {rem, low_bits[SCORE_W-1]};
  assign diff  = trial - {1'b0, den_q};

  // Control: busy for SCORE_W steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == STEP_W'(SCORE_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SCORE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: the upper part of num * 2^16 seeds the remainder, the rest is shifted in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num >> FRAC_W;
      low_bits <= {num[FRAC_W-1:0], {(SCORE_W - FRAC_W){1'b0}}};
      den_q    <= den;
      quotient <= '0;
    end else if (busy) begin
      if (!diff[PROD_W]) begin
        rem <= diff[PROD_W-1:0];
      end else begin
        rem <= trial[PROD_W-1:0];
      end
      quotient <= {quotient[SCORE_W-2:0], !diff[PROD_W]};
      low_bits <= {low_bits[SCORE_W-2:0], 1'b0};
    end
  end

endmodule
